// ----- rtl/core/deadband_pd_feedforward_axis_top_defines.svh -----
// ----------------------------------------------------------------------------
// deadband_pd_feedforward_axis_top_defines.svh
// Assertion macros used by the axis controller checker.
// ----------------------------------------------------------------------------
`ifndef DEADBAND_PD_FEEDFORWARD_AXIS_TOP_DEFINES_SVH
`define DEADBAND_PD_FEEDFORWARD_AXIS_TOP_DEFINES_SVH

// Clocked assertion, masked while reset is asserted
`define DBPD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Clocked assertion that stays live through reset
`define DBPD_ASSERT_RST(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/core/dbpd_pkg.sv -----
// ----------------------------------------------------------------------------
// dbpd_pkg
// Types, widths and constants shared by the axis speed controller.
// ----------------------------------------------------------------------------
package dbpd_pkg;

    // Field and datapath widths
    localparam int unsigned DATA_W     = 16;
    localparam int unsigned MUL_W      = 17;
    localparam int unsigned PROD_W     = 2 * MUL_W;
    localparam int unsigned CFG_IDX_W  = 3;

    // Shared divider: 36-bit dividend, 16-bit divisor, 4 quotient bits a cycle
    localparam int unsigned DIV_W      = 36;
    localparam int unsigned DSR_W      = 16;
    localparam int unsigned RADIX_BITS = 4;
    localparam int unsigned DIV_STEPS  = DIV_W / RADIX_BITS;
    localparam int unsigned DIV_CNT_W  = $clog2(DIV_STEPS);

    // Parameter defaults
    localparam int DEF_HW_MAX_SPEED     = 20000;
    localparam int DEF_DELTA_FILTER_DIV = 4;
    localparam int DEF_GAIN_UNITY       = 1024;

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEADBAND    = 3'd0,
        CFG_RESTART_DB  = 3'd1,
        CFG_PROP_GAIN   = 3'd2,
        CFG_DERIV_GAIN  = 3'd3,
        CFG_FF_GAIN     = 3'd4,
        CFG_GAIN_DIV    = 3'd5,
        CFG_MIN_SPEED   = 3'd6,
        CFG_MAX_SPEED   = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic [DATA_W-1:0] deadband;
        logic [DATA_W-1:0] restart_deadband;
        logic [DATA_W-1:0] prop_gain;
        logic [DATA_W-1:0] deriv_gain;
        logic [DATA_W-1:0] ff_gain;
        logic [DATA_W-1:0] gain_divisor;
        logic [DATA_W-1:0] min_speed;
        logic [DATA_W-1:0] max_speed;
    } t_cfg;

    // Multiplier request
    typedef struct packed {
        logic                     en;
        logic signed [MUL_W-1:0]  a;
        logic signed [MUL_W-1:0]  b;
    } t_mul_req;

    // Divider request and response
    typedef struct packed {
        logic              start;
        logic [DIV_W-1:0]  dividend;
        logic [DSR_W-1:0]  divisor;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [DIV_W-1:0]  quot;
    } t_div_rsp;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FILT_DIV,
        ST_ACT,
        ST_PD_M1,
        ST_PD_M2,
        ST_PD_SUM,
        ST_PD_DIV,
        ST_FF,
        ST_FF_M,
        ST_FF_DIV,
        ST_SUM,
        ST_G_M,
        ST_G_DIV,
        ST_DONE
    } t_state;

endpackage

// ----- rtl/core/dbpd_cfg.sv -----
// ----------------------------------------------------------------------------
// dbpd_cfg
// Configuration register file of the axis controller, write only.
// ----------------------------------------------------------------------------
module dbpd_cfg import dbpd_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [DATA_W-1:0]     i_cfg_data,
    output t_cfg                  o_cfg
);

    // Reset contents: all zero except a unity gain divisor
    localparam t_cfg CFG_RESET = '{gain_divisor: DATA_W'(1), default: '0};

    t_cfg r_cfg, n_cfg;

    // Write decode
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_DEADBAND:   n_cfg.deadband         = i_cfg_data;
                CFG_RESTART_DB: n_cfg.restart_deadband = i_cfg_data;
                CFG_PROP_GAIN:  n_cfg.prop_gain        = i_cfg_data;
                CFG_DERIV_GAIN: n_cfg.deriv_gain       = i_cfg_data;
                CFG_FF_GAIN:    n_cfg.ff_gain          = i_cfg_data;
                CFG_GAIN_DIV:   n_cfg.gain_divisor     = i_cfg_data;
                CFG_MIN_SPEED:  n_cfg.min_speed        = i_cfg_data;
                CFG_MAX_SPEED:  n_cfg.max_speed        = i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ----- rtl/core/dbpd_mul.sv -----
// ----------------------------------------------------------------------------
// dbpd_mul
// Shared 17x17 signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module dbpd_mul import dbpd_pkg::*; (
    input  logic                      i_clk,
    input  t_mul_req                  i_req,
    output logic signed [PROD_W-1:0]  o_prod
);

    logic signed [PROD_W-1:0] r_prod;

    // Product is registered and lands in the cycle after the request
    always_ff @(posedge i_clk) begin
        if (i_req.en) begin
            r_prod <= i_req.a * i_req.b;
        end
    end

    assign o_prod = r_prod;

endmodule

// ----- rtl/core/dbpd_div.sv -----
// ----------------------------------------------------------------------------
// dbpd_div
// Shared unsigned restoring divider, four quotient bits per cycle.
// ----------------------------------------------------------------------------
module dbpd_div import dbpd_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_div_req  i_req,
    output t_div_rsp  o_rsp
);

    logic                  r_busy;
    logic                  r_done;
    logic [DIV_CNT_W-1:0]  r_cnt;
    logic [DSR_W-1:0]      r_rem, n_rem;
    logic [DIV_W-1:0]      r_quo, n_quo;
    logic [DSR_W-1:0]      r_dsr;

    // Four shift/compare/subtract steps; dividend shifts out the top,
    // quotient bits shift in at the bottom
    always_comb begin
        logic [DSR_W:0]    t;
        logic [DSR_W-1:0]  rem;
        logic [DIV_W-1:0]  quo;
        rem = r_rem;
        quo = r_quo;
        for (int k = 0; k < RADIX_BITS; k++) begin
            t   = {rem, quo[DIV_W-1]};
            quo = {quo[DIV_W-2:0], 1'b0};
            if (t >= {1'b0, r_dsr}) begin
                t      = t - {1'b0, r_dsr};
                quo[0] = 1'b1;
            end
            rem = t[DSR_W-1:0];
        end
        n_rem = rem;
        n_quo = quo;
    end

    // Control; done pulses for one cycle after the last iteration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && !i_req.start && (r_cnt == DIV_CNT_W'(DIV_STEPS - 1));
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_quo <= i_req.dividend;
            r_dsr <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quo;

endmodule

// ----- rtl/core/deadband_pd_feedforward_axis_top.sv -----
// ----------------------------------------------------------------------------
// deadband_pd_feedforward_axis_top
// One axis of a vision-error stepper speed controller: PD law with deadband
// hysteresis, trend feedforward, speed clamp and Q output gain.
// ----------------------------------------------------------------------------
// One error sample is taken at a time; the input stalls until its result is
// in the output register. The shortest item (restart frame, idle axis, no
// feedforward, unity gain) skips the divider; the longest runs the filter
// update, the PD quotient, the feedforward quotient and the gain rounding,
// each one pass of the shared divider: a start request, then 9 iterations
// of 4 quotient bits and a done flag, plus registered products from the
// shared 17x17 multiplier. The next sample is accepted while a finished
// result still waits in the output register.
module deadband_pd_feedforward_axis_top import dbpd_pkg::*; #(
    parameter int HW_MAX_SPEED     = DEF_HW_MAX_SPEED,
    parameter int DELTA_FILTER_DIV = DEF_DELTA_FILTER_DIV,
    parameter int GAIN_UNITY       = DEF_GAIN_UNITY
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // configuration
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [DATA_W-1:0]        i_cfg_data,
    // sample in
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic signed [DATA_W-1:0] i_error,
    input  logic                     i_restart,
    input  logic [DATA_W-1:0]        i_out_gain,
    // command out
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic signed [DATA_W-1:0] o_speed_command,
    output logic signed [DATA_W-1:0] o_feed_forward,
    output logic                     o_axis_active
);

    localparam logic [DATA_W-1:0] HW16   = DATA_W'(HW_MAX_SPEED);
    localparam logic [DATA_W-1:0] FDIV16 = DATA_W'(DELTA_FILTER_DIV);
    localparam logic [DATA_W-1:0] GU16   = DATA_W'(GAIN_UNITY);

    // Saturate to the signed 16-bit range
    function automatic logic signed [DATA_W-1:0] sat16(input logic signed [18:0] v);
        logic signed [DATA_W-1:0] r;
        if (v > 19'sd32767)       r = 16'sh7FFF;
        else if (v < -19'sd32768) r = 16'sh8000;
        else                      r = v[DATA_W-1:0];
        return r;
    endfunction

    t_cfg       cfg;
    t_mul_req   mul_req;
    t_div_req   div_req;
    t_div_rsp   div_rsp;
    logic signed [PROD_W-1:0] prod;

    t_state r_state, n_state;

    logic signed [DATA_W-1:0] r_err, r_prev, r_fd, r_ff;
    logic [DATA_W-1:0]        r_gain;
    logic                     r_active, r_neg;
    logic signed [PROD_W-1:0] r_acc;
    logic signed [16:0]       r_pd, r_cmd;

    logic                     r_out_valid;
    logic signed [DATA_W-1:0] r_out_cmd, r_out_ff;
    logic                     r_out_act;

    // ------------------------------------------------------------------
    // Submodules
    // ------------------------------------------------------------------
    dbpd_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    dbpd_mul u_mul (
        .i_clk  (i_clk),
        .i_req  (mul_req),
        .o_prod (prod)
    );

    dbpd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // ------------------------------------------------------------------
    // Shared terms
    // ------------------------------------------------------------------
    logic              in_xfer, out_free;
    logic [DATA_W-1:0] lim, div_eff, gain_eff, rdb_eff, thr;
    logic [DIV_W-1:0]  quot;

    assign in_xfer  = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;
    assign quot     = div_rsp.quot;
    assign lim      = (cfg.max_speed > HW16) ? HW16 : cfg.max_speed;
    assign div_eff  = (cfg.gain_divisor == '0) ? DATA_W'(1) : cfg.gain_divisor;
    assign gain_eff = (r_gain == '0) ? GU16 : r_gain;
    assign rdb_eff  = (cfg.restart_deadband < cfg.deadband) ? cfg.deadband
                                                            : cfg.restart_deadband;
    assign thr      = r_active ? cfg.deadband : rdb_eff;

    // Derivative filter: sample delta and gap to the filtered value
    logic signed [16:0] sample_raw;
    logic signed [15:0] sample;
    logic signed [17:0] diff;
    logic [17:0]        diff_mag;
    logic [DIV_W-1:0]   filt_dividend;
    logic signed [18:0] fd_sum;

    assign sample_raw    = 17'(i_error) - 17'(r_prev);
    assign sample        = sat16(19'(sample_raw));
    assign diff          = 18'(sample) - 18'(r_fd);
    assign diff_mag      = diff[17] ? 18'(-diff) : 18'(diff);
    assign filt_dividend = DIV_W'(diff_mag) + DIV_W'(DELTA_FILTER_DIV - 1);
    assign fd_sum        = r_neg ? (19'(r_fd) - 19'({2'b00, quot[16:0]}))
                                 : (19'(r_fd) + 19'({2'b00, quot[16:0]}));

    // Deadband test on the error magnitude
    logic signed [16:0] err17;
    logic [16:0]        err_mag;
    logic               in_band;

    assign err17   = 17'(r_err);
    assign err_mag = err17[16] ? 17'(-err17) : 17'(err17);
    assign in_band = err_mag <= {1'b0, thr};

    // Magnitudes for the divider
    logic [PROD_W-1:0] acc_mag, prod_mag;

    assign acc_mag  = r_acc[PROD_W-1] ? PROD_W'(-r_acc) : PROD_W'(r_acc);
    assign prod_mag = prod[PROD_W-1]  ? PROD_W'(-prod)  : PROD_W'(prod);

    // PD speed from the quotient
    logic [16:0]        q_sat, a_floor, a_sel, a_cap1, a_cap;
    logic               pd_opp;
    logic signed [16:0] pd_val;

    always_comb begin
        if (r_neg) q_sat = (quot > DIV_W'(32768)) ? 17'd32768 : quot[16:0];
        else       q_sat = (quot > DIV_W'(32767)) ? 17'd32767 : quot[16:0];
        a_floor = (q_sat < {1'b0, cfg.min_speed}) ? {1'b0, cfg.min_speed} : q_sat;
        a_sel   = (quot == '0) ? {1'b0, cfg.min_speed} : a_floor;
        a_cap1  = (a_sel > {1'b0, cfg.max_speed}) ? {1'b0, cfg.max_speed} : a_sel;
        a_cap   = (a_cap1 > {1'b0, HW16}) ? {1'b0, HW16} : a_cap1;
        pd_opp  = (quot != '0) && (r_neg != r_err[DATA_W-1]);
        if (pd_opp)                  pd_val = '0;
        else if (r_err[DATA_W-1])    pd_val = -$signed(a_cap);
        else                         pd_val = $signed(a_cap);
    end

    // Feedforward from the quotient, clamped to the limit
    logic [DATA_W-1:0]        ff_mag;
    logic signed [DATA_W-1:0] ff_val;

    assign ff_mag = (quot > DIV_W'(lim)) ? lim : quot[DATA_W-1:0];
    assign ff_val = r_neg ? -$signed(ff_mag) : $signed(ff_mag);

    // PD plus feedforward, clamped
    logic signed [17:0] sum18, lim18;
    logic signed [16:0] cmd_val;
    logic               need_gain;

    assign sum18 = 18'(r_pd) + 18'(r_ff);
    assign lim18 = $signed({2'b00, lim});
    always_comb begin
        if (sum18 > lim18)       cmd_val = 17'(lim18);
        else if (sum18 < -lim18) cmd_val = 17'(-lim18);
        else                     cmd_val = 17'(sum18);
    end
    assign need_gain = (gain_eff != GU16) && (cmd_val != '0);

    // Output gain, rounded half away from zero, clamped to hardware limit
    logic [DIV_W-1:0]   g_dividend;
    logic [16:0]        g_mag;
    logic signed [16:0] g_val;

    assign g_dividend = DIV_W'(prod_mag) + DIV_W'(GAIN_UNITY / 2);
    assign g_mag      = (quot > DIV_W'(HW16)) ? {1'b0, HW16} : quot[16:0];
    assign g_val      = r_neg ? -$signed(g_mag) : $signed(g_mag);

    // ------------------------------------------------------------------
    // Sequencer: next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:     if (in_xfer) n_state = i_restart ? ST_ACT : ST_FILT_DIV;
            ST_FILT_DIV: if (div_rsp.done) n_state = ST_ACT;
            ST_ACT:      n_state = in_band ? ST_FF : ST_PD_M1;
            ST_PD_M1:    n_state = ST_PD_M2;
            ST_PD_M2:    n_state = ST_PD_SUM;
            ST_PD_SUM:   n_state = ST_PD_DIV;
            ST_PD_DIV:   if (div_rsp.done) n_state = ST_FF;
            ST_FF: begin
                if (r_fd != '0 && cfg.ff_gain != '0) n_state = ST_FF_M;
                else                                 n_state = ST_SUM;
            end
            ST_FF_M:     n_state = ST_FF_DIV;
            ST_FF_DIV:   if (div_rsp.done) n_state = ST_SUM;
            ST_SUM:      n_state = need_gain ? ST_G_M : ST_DONE;
            ST_G_M:      n_state = ST_G_DIV;
            ST_G_DIV:    if (div_rsp.done) n_state = ST_DONE;
            ST_DONE:     if (out_free) n_state = ST_IDLE;
            default:     n_state = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: unit requests
    // ------------------------------------------------------------------
    always_comb begin
        mul_req = '0;
        div_req = '0;
        case (r_state)
            ST_IDLE: begin
                if (in_xfer && !i_restart) begin
                    div_req.start    = 1'b1;
                    div_req.dividend = filt_dividend;
                    div_req.divisor  = FDIV16;
                end
            end
            ST_ACT: begin
                mul_req.en = !in_band;
                mul_req.a  = 17'(r_err);
                mul_req.b  = $signed({1'b0, cfg.prop_gain});
            end
            ST_PD_M1: begin
                mul_req.en = 1'b1;
                mul_req.a  = 17'(r_fd);
                mul_req.b  = $signed({1'b0, cfg.deriv_gain});
            end
            ST_PD_SUM: begin
                div_req.start    = 1'b1;
                div_req.dividend = DIV_W'(acc_mag);
                div_req.divisor  = div_eff;
            end
            ST_FF: begin
                mul_req.en = (r_fd != '0) && (cfg.ff_gain != '0);
                mul_req.a  = 17'(r_fd);
                mul_req.b  = $signed({1'b0, cfg.ff_gain});
            end
            ST_FF_M: begin
                div_req.start    = 1'b1;
                div_req.dividend = DIV_W'(prod_mag);
                div_req.divisor  = div_eff;
            end
            ST_SUM: begin
                mul_req.en = need_gain;
                mul_req.a  = cmd_val;
                mul_req.b  = $signed({1'b0, gain_eff});
            end
            ST_G_M: begin
                div_req.start    = 1'b1;
                div_req.dividend = g_dividend;
                div_req.divisor  = GU16;
            end
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // State, axis state and result registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_prev      <= '0;
            r_fd        <= '0;
            r_active    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            // Result register: filled on leaving ST_DONE, emptied by a transfer
            if (r_state == ST_DONE && out_free) r_out_valid <= 1'b1;
            else if (!i_out_stall)              r_out_valid <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (in_xfer) begin
                        r_err  <= i_error;
                        r_gain <= i_out_gain;
                        r_prev <= i_error;
                        r_neg  <= diff[17];
                        if (i_restart) r_fd <= '0;
                    end
                end
                ST_FILT_DIV: if (div_rsp.done) r_fd <= sat16(fd_sum);
                ST_ACT: begin
                    r_active <= !in_band;
                    if (in_band) r_pd <= '0;
                end
                ST_PD_M1:  r_acc <= prod;
                ST_PD_M2:  r_acc <= r_acc + prod;
                ST_PD_SUM: r_neg <= r_acc[PROD_W-1];
                ST_PD_DIV: if (div_rsp.done) r_pd <= pd_val;
                ST_FF: begin
                    if (r_fd == '0 || cfg.ff_gain == '0) r_ff <= '0;
                end
                ST_FF_M:   r_neg <= prod[PROD_W-1];
                ST_FF_DIV: if (div_rsp.done) r_ff <= ff_val;
                ST_SUM:    r_cmd <= cmd_val;
                ST_G_M:    r_neg <= prod[PROD_W-1];
                ST_G_DIV:  if (div_rsp.done) r_cmd <= g_val;
                ST_DONE: begin
                    if (out_free) begin
                        r_out_cmd   <= r_cmd[DATA_W-1:0];
                        r_out_ff    <= r_ff;
                        r_out_act   <= r_active;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_in_stall      = (r_state != ST_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_speed_command = r_out_cmd;
    assign o_feed_forward  = r_out_ff;
    assign o_axis_active   = r_out_act;

endmodule

// ----- rtl/core/dbpd_chk.sv -----
// ----------------------------------------------------------------------------
// dbpd_chk
// Port-level checks for the axis speed controller, bound to the top level.
// ----------------------------------------------------------------------------
`include "deadband_pd_feedforward_axis_top_defines.svh"

module dbpd_chk import dbpd_pkg::*; #(
    parameter int HW_MAX_SPEED = DEF_HW_MAX_SPEED
) (
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     i_in_valid,
    input logic                     o_in_stall,
    input logic                     o_out_valid,
    input logic                     i_out_stall,
    input logic signed [DATA_W-1:0] o_speed_command,
    input logic signed [DATA_W-1:0] o_feed_forward
);

    localparam logic signed [DATA_W:0] HW_P = (DATA_W + 1)'(HW_MAX_SPEED);
    localparam logic signed [DATA_W:0] HW_N = -HW_P;

    // Reset leaves the block idle with nothing to deliver
    `DBPD_ASSERT_RST(a_reset_idle, i_clk, !i_rst_n |=> !o_out_valid && !o_in_stall, "reset state")

    // A taken sample makes the block busy
    `DBPD_ASSERT(a_busy, i_clk, i_rst_n, i_in_valid && !o_in_stall |=> o_in_stall, "not busy")

    // Command stays within the hardware speed limit
    `DBPD_ASSERT(a_cmd_rng, i_clk, i_rst_n, o_out_valid |-> ((DATA_W + 1)'(o_speed_command) <= HW_P) && ((DATA_W + 1)'(o_speed_command) >= HW_N), "command range")

    // Feedforward stays within the hardware speed limit
    `DBPD_ASSERT(a_ff_rng, i_clk, i_rst_n, o_out_valid |-> ((DATA_W + 1)'(o_feed_forward) <= HW_P) && ((DATA_W + 1)'(o_feed_forward) >= HW_N), "feedforward range")

    // A stalled result transfer holds
    `DBPD_ASSERT(a_hold, i_clk, i_rst_n, o_out_valid && i_out_stall |=> o_out_valid && $stable(o_speed_command) && $stable(o_feed_forward), "result changed while stalled")

endmodule

bind deadband_pd_feedforward_axis_top dbpd_chk #(
    .HW_MAX_SPEED (HW_MAX_SPEED)
) u_dbpd_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in_valid),
    .o_in_stall      (o_in_stall),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_speed_command (o_speed_command),
    .o_feed_forward  (o_feed_forward)
);

// ----- sim/tb_deadband_pd_feedforward_axis_top.sv -----
// ----------------------------------------------------------------------------
// tb_deadband_pd_feedforward_axis_top
// Self-checking bench for one axis of the vision-error speed controller.
// Error samples go in over a valid/stall port and commands come back the
// same way. A behavioral predictor tracks the last error, the filtered
// derivative and the active flag, and computes each expected command,
// feedforward and active bit. Hand-picked corner cases come first, then
// random tracking sequences over many register settings, with random
// idling and stalling on both ports.
// ----------------------------------------------------------------------------
module tb_deadband_pd_feedforward_axis_top;
    import dbpd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam longint HW_MAX      = DEF_HW_MAX_SPEED;
    localparam longint FILT_DIV    = DEF_DELTA_FILTER_DIV;
    localparam longint GAIN_ONE    = DEF_GAIN_UNITY;
    localparam int     CYCLE_LIMIT = 1_000_000;
    localparam int     DRAIN_WAIT  = 60;

    typedef struct packed {
        logic [DATA_W-1:0] speed;
        logic [DATA_W-1:0] ff;
        logic              active;
    } axis_cmd_t;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_cfg_we;
    logic [CFG_IDX_W-1:0]     i_cfg_idx;
    logic [DATA_W-1:0]        i_cfg_data;
    logic                     i_in_valid;
    logic                     o_in_stall;
    logic signed [DATA_W-1:0] i_error;
    logic                     i_restart;
    logic [DATA_W-1:0]        i_out_gain;
    logic                     o_out_valid;
    logic                     i_out_stall = 1'b0;
    logic signed [DATA_W-1:0] o_speed_command;
    logic signed [DATA_W-1:0] o_feed_forward;
    logic                     o_axis_active;

    // Predictor copy of registers and axis state
    logic [DATA_W-1:0]        reg_file [8];
    logic signed [DATA_W-1:0] last_error;
    logic signed [DATA_W-1:0] trend_delta;
    logic                     axis_on;

    axis_cmd_t expected_cmds [$];
    int        send_idle_pct  = 20;
    int        recv_stall_pct = 52;
    int        error_count    = 0;
    int        samples_sent   = 0;
    int        cmds_checked   = 0;
    int        configs_loaded = 0;
    int        cycle_count    = 0;

    deadband_pd_feedforward_axis_top uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_error         (i_error),
        .i_restart       (i_restart),
        .i_out_gain      (i_out_gain),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_speed_command (o_speed_command),
        .o_feed_forward  (o_feed_forward),
        .o_axis_active   (o_axis_active)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d commands pending",
                     cycle_count, expected_cmds.size());
            $display("tb_deadband_pd_feedforward_axis_top: FAIL");
            $finish;
        end
    end

    task automatic flag_error(input string msg);
        error_count++;
        if (error_count <= 40)
            $display("ERROR @%0t: %s", $time, msg);
    endtask

    function automatic longint sat16(input longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    function automatic longint clamp_sym(input longint v, input longint lim);
        if (v > lim) return lim;
        if (v < -lim) return -lim;
        return v;
    endfunction

    // Derivative filter, deadband hysteresis, PD, feedforward, clamp, Q gain
    function automatic axis_cmd_t predict_command(input logic signed [DATA_W-1:0] err_in,
                                                  input logic rst_in,
                                                  input logic [DATA_W-1:0] gain_in);
        longint    err, db, rdb, kp, kd, kff, div, vmin, vmax, lim;
        longint    diff, adj, fd, mag, q, a, pd, ff, cmd, gain, s;
        axis_cmd_t res;
        err  = err_in;
        db   = reg_file[CFG_DEADBAND];
        rdb  = reg_file[CFG_RESTART_DB];
        kp   = reg_file[CFG_PROP_GAIN];
        kd   = reg_file[CFG_DERIV_GAIN];
        kff  = reg_file[CFG_FF_GAIN];
        div  = reg_file[CFG_GAIN_DIV];
        vmin = reg_file[CFG_MIN_SPEED];
        vmax = reg_file[CFG_MAX_SPEED];
        if (div == 0) div = 1;
        lim = (vmax > HW_MAX) ? HW_MAX : vmax;

        // quarter-step filter toward the newest error change, away from zero
        if (rst_in) begin
            trend_delta = '0;
        end else begin
            diff = sat16(err - longint'(last_error)) - longint'(trend_delta);
            if (diff > 0) adj = (diff + FILT_DIV - 1) / FILT_DIV;
            else if (diff < 0) adj = -((-diff + FILT_DIV - 1) / FILT_DIV);
            else adj = 0;
            trend_delta = 16'(sat16(longint'(trend_delta) + adj));
        end
        last_error = err_in;
        fd = trend_delta;

        // PD with hysteresis: idle axis needs the wider restart band
        mag = (err < 0) ? -err : err;
        if (rdb < db) rdb = db;
        pd = 0;
        if (mag <= (axis_on ? db : rdb)) begin
            axis_on = 1'b0;
        end else begin
            axis_on = 1'b1;
            q = (err * kp + fd * kd) / div;
            // opposite-sign PD is dropped; zero quotient gets the floor
            if (!((err > 0 && q < 0) || (err < 0 && q > 0))) begin
                a = sat16(q);
                if (a < 0) a = -a;
                if (a < vmin) a = vmin;
                if (a > vmax) a = vmax;
                if (a > HW_MAX) a = HW_MAX;
                pd = (err < 0) ? -a : a;
            end
        end

        ff = 0;
        if (fd != 0 && kff != 0) ff = clamp_sym((fd * kff) / div, lim);
        cmd = clamp_sym(pd + ff, lim);

        // Q output gain, half away from zero
        gain = gain_in;
        if (gain == 0) gain = GAIN_ONE;
        if (gain != GAIN_ONE && cmd != 0) begin
            s = cmd * gain;
            s = (s > 0) ? s + GAIN_ONE / 2 : s - GAIN_ONE / 2;
            cmd = clamp_sym(s / GAIN_ONE, HW_MAX);
        end

        res.speed  = 16'(cmd);
        res.ff     = 16'(ff);
        res.active = axis_on;
        return res;
    endfunction

    // Output side: check each transfer, then pick the next stall
    always @(posedge i_clk) begin : check_cmds
        axis_cmd_t want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_cmds.size() == 0) begin
                flag_error($sformatf("command %0d with nothing expected",
                                     $signed(o_speed_command)));
            end else begin
                want = expected_cmds.pop_front();
                cmds_checked++;
                if (o_speed_command !== want.speed)
                    flag_error($sformatf("speed_command got %0d want %0d",
                                         $signed(o_speed_command), $signed(want.speed)));
                if (o_feed_forward !== want.ff)
                    flag_error($sformatf("feed_forward got %0d want %0d",
                                         $signed(o_feed_forward), $signed(want.ff)));
                if (o_axis_active !== want.active)
                    flag_error($sformatf("axis_active got %b want %b",
                                         o_axis_active, want.active));
            end
        end
        i_out_stall <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
    end

    // One input transfer; valid stays high afterwards so back-to-back works
    task automatic send_sample(input logic signed [DATA_W-1:0] err,
                               input logic rst,
                               input logic [DATA_W-1:0] gain);
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_in_valid <= 1'b1;
        i_error    <= err;
        i_restart  <= rst;
        i_out_gain <= gain;
        do @(posedge i_clk); while (o_in_stall);
        expected_cmds.push_back(predict_command(err, rst, gain));
        samples_sent++;
    endtask

    // Drop valid and let every outstanding command come back
    task automatic wait_quiet();
        i_in_valid <= 1'b0;
        while (expected_cmds.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [DATA_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        reg_file[idx] = val;
    endtask

    task automatic configure(input logic [DATA_W-1:0] db, input logic [DATA_W-1:0] rdb,
                             input logic [DATA_W-1:0] kp, input logic [DATA_W-1:0] kd,
                             input logic [DATA_W-1:0] kff, input logic [DATA_W-1:0] div,
                             input logic [DATA_W-1:0] vmin, input logic [DATA_W-1:0] vmax);
        wait_quiet();
        write_reg(CFG_DEADBAND, db);
        write_reg(CFG_RESTART_DB, rdb);
        write_reg(CFG_PROP_GAIN, kp);
        write_reg(CFG_DERIV_GAIN, kd);
        write_reg(CFG_FF_GAIN, kff);
        write_reg(CFG_GAIN_DIV, div);
        write_reg(CFG_MIN_SPEED, vmin);
        write_reg(CFG_MAX_SPEED, vmax);
        i_cfg_we <= 1'b0;
        configs_loaded++;
    endtask

    function automatic logic [DATA_W-1:0] rand_reg(input int hi);
        if ($urandom_range(5) == 0) return 16'($urandom);
        return 16'($urandom_range(hi));
    endfunction

    function automatic logic [DATA_W-1:0] pick_gain();
        case ($urandom_range(3))
            0:       return 16'd0;
            1:       return 16'(GAIN_ONE);
            2:       return 16'($urandom_range(2048, 512));
            default: return 16'($urandom);
        endcase
    endfunction

    // Register defaults after reset: zero gains and zero speed limit
    task automatic test_reset_values();
        send_sample(16'sd0, 1'b0, 16'd0);
        send_sample(16'sd7, 1'b0, 16'd0);
        send_sample(16'sh8000, 1'b1, 16'hFFFF);
    endtask

    task automatic test_special_cases();
        // restart band below deadband, zero divisor, hard speed cap
        configure(16'd100, 16'd40, 16'd256, 16'd0, 16'd0, 16'd0, 16'd0, 16'hFFFF);
        send_sample(16'sd0, 1'b1, 16'd0);
        send_sample(16'sd100, 1'b1, 16'd1024);
        send_sample(16'sd101, 1'b0, 16'd0);
        send_sample(16'sh8000, 1'b1, 16'hFFFF);
        send_sample(16'sd32767, 1'b1, 16'd1);
        send_sample(-16'sd5, 1'b1, 16'd3000);

        // hysteresis, min-speed floor on a zero quotient, opposite-sign PD
        configure(16'd50, 16'd200, 16'd1, 16'd512, 16'd64, 16'd256, 16'd30, 16'd500);
        send_sample(16'sd150, 1'b1, 16'd0);
        send_sample(16'sd250, 1'b1, 16'd0);
        send_sample(16'sd120, 1'b1, 16'd0);
        send_sample(16'sd50, 1'b1, 16'd0);
        send_sample(16'sd120, 1'b1, 16'd0);
        send_sample(16'sd300, 1'b1, 16'd0);
        send_sample(16'sd210, 1'b0, 16'd1536);
    endtask

    task automatic test_config_extremes();
        // everything at full scale: axis never starts, feedforward follows the filtered delta
        configure(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                  16'hFFFF);
        send_sample(16'sh8000, 1'b1, 16'd0);
        send_sample(16'sd32767, 1'b0, 16'd1024);
        send_sample(16'sh8000, 1'b0, 16'hFFFF);
        // everything zero: feedforward off, zero divisor, zero limit
        configure(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        send_sample(16'sd1, 1'b0, 16'd2048);
        send_sample(16'sd0, 1'b0, 16'd0);
        send_sample(-16'sd1, 1'b0, 16'd1);
    endtask

    // Tracking runs: restart, then errors decaying with noise; a few jumps
    // and stray restarts break the sequences
    task automatic test_random_traffic();
        int                       phase, cfg_n, left, len, k, spread, noise;
        longint                   e, band;
        logic                     rst;
        for (phase = 0; phase < 3; phase++) begin
            case (phase)
                0:       begin send_idle_pct = 20; recv_stall_pct = 52; end
                1:       begin send_idle_pct = 52; recv_stall_pct = 20; end
                default: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            endcase
            for (cfg_n = 0; cfg_n < 4; cfg_n++) begin
                configure(rand_reg(400), rand_reg(900), rand_reg(3000), rand_reg(6000),
                          ($urandom_range(3) == 0) ? 16'd0 : rand_reg(2000),
                          rand_reg(512), rand_reg(300), rand_reg(25000));
                left = 66;
                while (left > 0) begin
                    len = $urandom_range(30, 3);
                    if (len > left) len = left;
                    spread = $urandom_range(60);
                    band = $urandom_range(1)
                         ? longint'(reg_file[CFG_DEADBAND]) : longint'(reg_file[CFG_RESTART_DB]);
                    case ($urandom_range(3))
                        0:       e = $signed(16'($urandom));
                        1:       e = $urandom_range(2000);
                        2:       e = band + longint'($urandom_range(40)) - 20;
                        default: e = $urandom_range(200);
                    endcase
                    if ($urandom_range(1) == 1) e = -e;
                    send_sample(16'(sat16(e)), 1'b1, pick_gain());
                    e = sat16(e);
                    for (k = 1; k < len; k++) begin
                        if ($urandom_range(24) == 0) begin
                            e = $signed(16'($urandom));
                        end else begin
                            noise = int'($urandom_range(2 * spread)) - spread;
                            e = sat16(e - e / longint'($urandom_range(8, 2)) + noise);
                        end
                        rst = ($urandom_range(29) == 0);
                        send_sample(16'(e), rst, pick_gain());
                    end
                    left -= len;
                end
            end
        end
    endtask

    initial begin
        // predictor state after reset
        foreach (reg_file[j]) reg_file[j] = '0;
        reg_file[CFG_GAIN_DIV] = 16'd1;
        last_error  = '0;
        trend_delta = '0;
        axis_on     = 1'b0;

        i_rst_n    <= 1'b0;
        i_cfg_we   <= 1'b0;
        i_cfg_idx  <= CFG_DEADBAND;
        i_cfg_data <= '0;
        i_in_valid <= 1'b0;
        i_error    <= '0;
        i_restart  <= 1'b0;
        i_out_gain <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_values();
        test_special_cases();
        test_config_extremes();
        test_random_traffic();

        // let late or extra commands show up
        wait_quiet();
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (expected_cmds.size() != 0)
            flag_error($sformatf("%0d commands never arrived", expected_cmds.size()));

        $display("Ran %0d error samples through %0d register settings, corners first",
                 samples_sent, configs_loaded);
        $display("Compared %0d commands, %0d mismatches", cmds_checked, error_count);
        if (error_count == 0) begin
            $display("tb_deadband_pd_feedforward_axis_top: PASS");
        end else begin
            $display("tb_deadband_pd_feedforward_axis_top: FAIL");
        end
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/dbpd_pkg.sv
rtl/core/dbpd_cfg.sv
rtl/core/dbpd_mul.sv
rtl/core/dbpd_div.sv
rtl/core/deadband_pd_feedforward_axis_top.sv
rtl/core/dbpd_chk.sv
sim/tb_deadband_pd_feedforward_axis_top.sv
